>>> rtl/dhkv_pkg.sv
package dhkv_pkg;

    // table geometry
    localparam int TABLE_SIZE = 1021;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int SLOT_W     = 2;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    // key reduction, one digit per step
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = KEY_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // slot codes
    localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_USED  = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_GONE  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] found_value;
    } response_t;

    // microprogram steps
    typedef enum logic [2:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_MOD,
        STEP_READ,
        STEP_CHECK,
        STEP_FINISH
    } step_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_MOD,
        OP_READ,
        OP_CHECK,
        OP_FINISH
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_CLEAR_LAST,
        COND_IN_TAKE,
        COND_MOD_LAST,
        COND_PROBE_END,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } uword_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic probe_end;
    } dp_flags_t;

    typedef struct packed {
        logic clear_last;
        logic in_take;
        logic mod_last;
        logic probe_end;
        logic out_free;
    } flags_t;

    // control store
    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            STEP_CLEAR:  w = '{OP_CLEAR,  COND_CLEAR_LAST, STEP_IDLE,   STEP_CLEAR};
            STEP_IDLE:   w = '{OP_LOAD,   COND_IN_TAKE,    STEP_MOD,    STEP_IDLE};
            STEP_MOD:    w = '{OP_MOD,    COND_MOD_LAST,   STEP_READ,   STEP_MOD};
            STEP_READ:   w = '{OP_READ,   COND_ALWAYS,     STEP_CHECK,  STEP_CHECK};
            STEP_CHECK:  w = '{OP_CHECK,  COND_PROBE_END,  STEP_FINISH, STEP_READ};
            STEP_FINISH: w = '{OP_FINISH, COND_OUT_FREE,   STEP_IDLE,   STEP_FINISH};
            default:     w = '{OP_LOAD,   COND_ALWAYS,     STEP_IDLE,   STEP_IDLE};
        endcase
        return w;
    endfunction

    // one bit of a restoring remainder: (r * 2 + b) mod m, with r < m
    function automatic idx_t mod_shift(idx_t r, logic b, logic [IDX_W:0] m);
        logic [IDX_W:0] t;
        t = {r, b};
        if (t >= m) begin
            t = t - m;
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/dhkv_ram.sv
module dhkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dhkv_seq.sv
module dhkv_seq
    import dhkv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output uword_t uw
);

    step_t step_reg;
    step_t step_next;
    logic  cond_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // next step: conditional jump
    always_comb
    begin
        unique case (uw.cond)
            COND_ALWAYS:     cond_hit = 1'b1;
            COND_CLEAR_LAST: cond_hit = flags.clear_last;
            COND_IN_TAKE:    cond_hit = flags.in_take;
            COND_MOD_LAST:   cond_hit = flags.mod_last;
            COND_PROBE_END:  cond_hit = flags.probe_end;
            COND_OUT_FREE:   cond_hit = flags.out_free;
            default:         cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? uw.on_true : uw.on_false;
    end

    // control word out of the store
    always_comb
    begin
        uw = ucode(step_reg);
    end

endmodule

>>> rtl/dhkv_dp.sv
module dhkv_dp
    import dhkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  uword_t    uw,
    input  logic      take,
    input  request_t  request,
    output response_t result,
    output dp_flags_t flags
);

    localparam logic [IDX_W:0] MOD_POS  = (IDX_W+1)'(TABLE_SIZE);
    localparam logic [IDX_W:0] MOD_SKIP = (IDX_W+1)'(TABLE_SIZE - 1);
    localparam idx_t           LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [DIG_CNT_W-1:0] LAST_DIG = DIG_CNT_W'(DIGITS - 1);

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [KEY_W-1:0]        shift_reg, shift_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    idx_t                    pos_reg, pos_next;
    idx_t                    skip_reg, skip_next;
    logic [DIG_CNT_W-1:0]    dig_cnt_reg, dig_cnt_next;
    idx_t                    probe_cnt_reg, probe_cnt_next;
    idx_t                    clr_cnt_reg, clr_cnt_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic signed [VAL_W-1:0] found_reg, found_next;

    logic                    st_we;
    idx_t                    st_waddr;
    logic [SLOT_W-1:0]       st_wdata;
    logic [SLOT_W-1:0]       st_rdata;
    logic                    ent_we;
    logic [KEY_W+VAL_W-1:0]  ent_rdata;

    logic                    hit;
    logic                    empty;
    logic                    last;
    idx_t                    step_size;
    logic [IDX_W:0]          pos_sum;
    idx_t                    pos_adv;

    dhkv_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (pos_reg),
        .rdata (st_rdata)
    );

    dhkv_ram #(
        .WIDTH (KEY_W + VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (pos_reg),
        .wdata ({key_reg, value_reg}),
        .raddr (pos_reg),
        .rdata (ent_rdata)
    );

    assign empty = (st_rdata == SLOT_EMPTY);
    assign hit   = (st_rdata == SLOT_USED) && (ent_rdata[KEY_W+VAL_W-1:VAL_W] == key_reg);
    assign last  = (probe_cnt_reg == LAST_IDX);

    // next probe slot, both terms below the table size
    assign step_size = skip_reg + idx_t'(1);
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, step_size};
    assign pos_adv   = (pos_sum >= MOD_POS) ? idx_t'(pos_sum - MOD_POS)
                                            : pos_sum[IDX_W-1:0];

    assign flags.clear_last = (clr_cnt_reg == LAST_IDX);
    assign flags.mod_last   = (dig_cnt_reg == LAST_DIG);
    assign flags.probe_end  = empty || hit || last;

    assign result.status      = status_reg;
    assign result.found_value = found_reg;

    always_comb
    begin
        idx_t p;
        idx_t s;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        shift_next     = shift_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        dig_cnt_next   = dig_cnt_reg;
        probe_cnt_next = probe_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        st_we          = 1'b0;
        st_waddr       = pos_reg;
        st_wdata       = SLOT_EMPTY;
        ent_we         = 1'b0;
        p              = pos_reg;
        s              = skip_reg;

        unique case (uw.op)
            OP_CLEAR:
            begin
                st_we        = 1'b1;
                st_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + idx_t'(1);
            end
            OP_LOAD:
            begin
                if (take)
                begin
                    cmd_next       = request.command;
                    key_next       = request.key;
                    shift_next     = request.key;
                    value_next     = request.value;
                    pos_next       = '0;
                    skip_next      = '0;
                    dig_cnt_next   = '0;
                    probe_cnt_next = '0;
                    status_next    = ST_MISS;
                    found_next     = '0;
                end
            end
            OP_MOD:
            begin
                // home slot and probe stride, msb first
                for (int d = 0; d < DIGIT_W; d++)
                begin
                    p = mod_shift(p, shift_reg[KEY_W-1-d], MOD_POS);
                    s = mod_shift(s, shift_reg[KEY_W-1-d], MOD_SKIP);
                end
                pos_next     = p;
                skip_next    = s;
                shift_next   = shift_reg << DIGIT_W;
                dig_cnt_next = dig_cnt_reg + DIG_CNT_W'(1);
            end
            OP_READ:
            begin
            end
            OP_CHECK:
            begin
                if (hit)
                begin
                    unique case (cmd_reg)
                        CMD_INSERT: status_next = ST_DUP;
                        CMD_SEARCH:
                        begin
                            status_next = ST_OK;
                            found_next  = signed'(ent_rdata[VAL_W-1:0]);
                        end
                        CMD_DELETE:
                        begin
                            status_next = ST_OK;
                            st_we       = 1'b1;
                            st_wdata    = SLOT_GONE;
                        end
                        default:    status_next = ST_MISS;
                    endcase
                end
                else if (empty)
                begin
                    if (cmd_reg == CMD_INSERT)
                    begin
                        status_next = ST_OK;
                        st_we       = 1'b1;
                        st_wdata    = SLOT_USED;
                        ent_we      = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_MISS;
                    end
                end
                else if (last)
                begin
                    status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_MISS;
                end
                else
                begin
                    pos_next       = pos_adv;
                    probe_cnt_next = probe_cnt_reg + idx_t'(1);
                end
            end
            OP_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            dig_cnt_reg   <= dig_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        shift_reg  <= shift_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        skip_reg   <= skip_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

>>> rtl/double_hash_key_value_table.sv
// open-addressed key/value table with double hashing
// request channel: request_valid / request_stall carry one transaction with
//   command (insert, search, delete), key and value
// response channel: response_valid / response_stall carry one transaction
//   per request with status and found_value
// a request is taken only while the sequencer waits in its idle step; from
//   then on request_stall stays high until the result is handed over
// sequence: key reduction (4 key bits per cycle), then per probe a slot read
//   and a check step, for p = 1..TABLE_SIZE probes, then a finish step that
//   loads the response register once it is free
// one transaction at a time: a request is taken only once the previous result
//   is loaded; the probe loop walks one slot at a time on the single RAM read port
// reset: a clearing pass writes all TABLE_SIZE (1021) slots empty, one slot a
//   cycle; request_stall is high during the pass
// receiver stall: the response register holds its transaction; the block
//   still takes and works on the next request and waits before writing the
//   response register only if the previous response has not left
module double_hash_key_value_table
    import dhkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      request_valid,
    output logic      request_stall,
    input  request_t  request,
    output logic      response_valid,
    input  logic      response_stall,
    output response_t response
);

    uword_t    uw;
    flags_t    flags;
    dp_flags_t dp_flags;
    response_t result;
    logic      take;
    logic      out_free;
    logic      load_out;

    logic      response_valid_reg, response_valid_next;
    response_t response_reg, response_next;

    // requests only in the idle step
    assign request_stall = (uw.op != OP_LOAD);
    assign take          = request_valid && !request_stall;

    // response register empty or emptying this cycle
    assign out_free = !response_valid_reg || !response_stall;
    assign load_out = (uw.op == OP_FINISH) && out_free;

    assign flags.clear_last = dp_flags.clear_last;
    assign flags.in_take    = take;
    assign flags.mod_last   = dp_flags.mod_last;
    assign flags.probe_end  = dp_flags.probe_end;
    assign flags.out_free   = out_free;

    dhkv_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uw    (uw)
    );

    dhkv_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .uw      (uw),
        .take    (take),
        .request (request),
        .result  (result),
        .flags   (dp_flags)
    );

    // output register
    always_comb
    begin
        response_valid_next = response_valid_reg;
        response_next       = response_reg;
        if (load_out)
        begin
            response_valid_next = 1'b1;
            response_next       = result;
        end
        else if (!response_stall)
        begin
            response_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response_valid_reg <= 1'b0;
        end
        else
        begin
            response_valid_reg <= response_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        response_reg <= response_next;
    end

    assign response_valid = response_valid_reg;
    assign response       = response_reg;

endmodule

>>> rtl/dhkv_checker.sv
module dhkv_checker
    import dhkv_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      request_valid,
    input logic      request_stall,
    input request_t  request,
    input logic      response_valid,
    input logic      response_stall,
    input response_t response
);

    // a stalled response stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && response_stall |=> response_valid)
        else $error("response dropped while stalled");

    // a stalled response holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && response_stall |=> $stable(response))
        else $error("response changed while stalled");

    // one request at a time: busy right after a transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall |=> request_stall)
        else $error("request taken while busy");

    // found_value is nonzero only on success
    assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && (response.status != ST_OK) |-> (response.found_value == '0))
        else $error("found_value set on a failed operation");

    // the edge that takes a request, with no response pending, loads no response
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && !request_stall && !response_valid |=> !response_valid)
        else $error("response too early");

endmodule

bind double_hash_key_value_table dhkv_checker u_checker (.*);

>>> tb/kv_table_checker.sv
`timescale 1ns / 100ps

module kv_table_checker
    import dhkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      request_valid,
    input  logic      request_stall,
    input  request_t  request,
    input  logic      response_valid,
    input  logic      response_stall,
    input  response_t response,
    output int        failures,
    output int        outstanding
);

    // shadow copy of the slot store
    logic [SLOT_W-1:0]       shadow_status [TABLE_SIZE];
    logic [KEY_W-1:0]        shadow_key    [TABLE_SIZE];
    logic signed [VAL_W-1:0] shadow_value  [TABLE_SIZE];

    response_t awaited_responses [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        foreach (shadow_status[i])
        begin
            shadow_status[i] = SLOT_EMPTY;
        end
    end

    // walk the double-hash chain of one key, update the shadow store, give the result
    function automatic response_t probe_and_update(request_t req);
        int unsigned pos;
        int unsigned stride;
        int unsigned probes;
        int          hit;
        int          hole;
        response_t   rsp;
        pos                 = req.key % TABLE_SIZE;
        stride              = 1 + req.key % (TABLE_SIZE - 1);
        probes              = 0;
        hit                 = -1;
        hole                = -1;
        rsp.status          = ST_MISS;
        rsp.found_value     = '0;
        while (probes < TABLE_SIZE && hit < 0 && hole < 0)
        begin
            if (shadow_status[pos] == SLOT_EMPTY)
                hole = pos;
            else if (shadow_status[pos] == SLOT_USED && shadow_key[pos] == req.key)
                hit = pos;
            pos = (pos + stride) % TABLE_SIZE;
            probes++;
        end
        case (req.command)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    rsp.status = ST_DUP;
                end
                else if (hole >= 0)
                begin
                    shadow_status[hole] = SLOT_USED;
                    shadow_key[hole]    = req.key;
                    shadow_value[hole]  = req.value;
                    rsp.status          = ST_OK;
                end
                else
                begin
                    rsp.status = ST_FULL;
                end
            end
            CMD_SEARCH:
            begin
                if (hit >= 0)
                begin
                    rsp.status      = ST_OK;
                    rsp.found_value = shadow_value[hit];
                end
            end
            CMD_DELETE:
            begin
                if (hit >= 0)
                begin
                    shadow_status[hit] = SLOT_GONE;
                    rsp.status         = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    always @(posedge clk)
    begin : watch
        response_t want;
        if (rst_n)
        begin
            // a response can never belong to a request taken at the same edge
            if (response_valid && !response_stall)
            begin
                if (awaited_responses.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: unexpected response transaction: status %0d found_value %0d",
                                 $time, response.status, response.found_value);
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (response.status !== want.status ||
                        response.found_value !== want.found_value)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: response mismatch: status exp %0d got %0d, ",
                                      "found_value exp %0d got %0d"},
                                     $time, want.status, response.status,
                                     want.found_value, response.found_value);
                    end
                end
            end
            if (request_valid && !request_stall)
                awaited_responses.push_back(probe_and_update(request));
            outstanding <= awaited_responses.size();
        end
    end

endmodule

>>> tb/double_hash_key_value_table_tb.sv
`timescale 1ns / 100ps

module double_hash_key_value_table_tb;
    import dhkv_pkg::*;

    // the one command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // a full-length probe walk plus key reduction and margin
    localparam int SETTLE_CYCLES    = 2 * TABLE_SIZE + 32;
    // sender waits for an empty pipeline this often
    localparam int DRAIN_EVERY      = 300;
    // transactions sent once every slot has been used
    localparam int FULL_TABLE_ITEMS = 60;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      request_valid;
    logic      request_stall;
    request_t  request;
    logic      response_valid;
    logic      response_stall;
    response_t response;

    int failures;
    int outstanding;

    // stimulus bookkeeping: which keys are stored, which were deleted,
    // and how many slots have left the empty state for good
    bit               live_set  [bit [KEY_W-1:0]];
    logic [KEY_W-1:0] live_keys [$];
    logic [KEY_W-1:0] dead_keys [$];
    int               slots_taken = 0;

    // burst modes: while set, that side never idles
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned rx_hold  = 0;

    always #4 clk = ~clk;

    double_hash_key_value_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .request        (request),
        .response_valid (response_valid),
        .response_stall (response_stall),
        .response       (response)
    );

    kv_table_checker table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .request        (request),
        .response_valid (response_valid),
        .response_stall (response_stall),
        .response       (response),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    // receiver: after each response transaction stall may be held high for a random hold; in quiet mode it stays low
    always @(posedge clk)
    begin : receiver
        int unsigned hold;
        if (rst_n)
        begin
            if (rx_hold != 0)
            begin
                rx_hold        <= rx_hold - 1;
                response_stall <= (rx_hold > 1);
            end
            else if (response_valid && !response_stall)
            begin
                if ($urandom_range(0, 99) < 3)
                    rx_quiet <= !rx_quiet;
                hold           = rx_quiet ? 0 : $urandom_range(0, 6);
                rx_hold        <= hold;
                response_stall <= (hold != 0);
            end
        end
    end

    // a key not stored right now: sometimes one deleted earlier, sometimes one
    // whose home slot is crowded, mostly anything
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] key;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 10 && dead_keys.size() != 0)
            key = dead_keys[$urandom_range(0, dead_keys.size() - 1)];
        else if (pick < 35)
            key = $urandom_range(0, 4000) * TABLE_SIZE + $urandom_range(0, 3);
        else
            key = $urandom;
        while (live_set.exists(key))
            key = $urandom;
        return key;
    endfunction

    // a stored key with the given chance in percent, else a fresh one
    function automatic logic [KEY_W-1:0] pick_key(int live_pct);
        if (live_keys.size() != 0 && $urandom_range(0, 99) < live_pct)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return fresh_key();
    endfunction

    // one request transaction; returns at the edge that takes it, valid still high
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic signed [VAL_W-1:0] value);
        request_t txn;
        int       gap;
        int       idx;
        if ($urandom_range(0, 99) < 3)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        txn.command   = cmd;
        txn.key       = key;
        txn.value     = value;
        request_valid <= 1'b1;
        request       <= txn;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        // track occupancy so the stimulus knows when the table is full
        if (cmd == CMD_INSERT && !live_set.exists(key) && slots_taken < TABLE_SIZE)
        begin
            live_set[key] = 1'b1;
            live_keys.push_back(key);
            slots_taken++;
        end
        else if (cmd == CMD_DELETE && live_set.exists(key))
        begin
            live_set.delete(key);
            idx = 0;
            foreach (live_keys[i])
            begin
                if (live_keys[i] == key)
                    idx = i;
            end
            live_keys.delete(idx);
            dead_keys.push_back(key);
        end
    endtask

    // stop sending and wait until every response has come back
    task automatic drain_table();
        request_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    initial
    begin : stimulus
        int pick;
        int sent;
        rst_n          = 1'b0;
        request_valid  = 1'b0;
        request        = '0;
        response_stall = 1'b0;
        sent           = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, field extremes, collisions, tombstones
        send_item(CMD_SEARCH, 32'd0, 32'sd0);
        send_item(CMD_DELETE, 32'd0, 32'sd0);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, -32'sd1);
        send_item(CMD_INSERT, 32'd0, 32'sh7FFF_FFFF);
        send_item(CMD_INSERT, 32'd0, 32'sd5);                          // duplicate key
        send_item(CMD_SEARCH, 32'd0, 32'sd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000);
        send_item(CMD_SEARCH, 32'hFFFF_FFFF, 32'sd0);
        // same home slot as key 0, different strides
        send_item(CMD_INSERT, TABLE_SIZE, -32'sd1);
        send_item(CMD_INSERT, 2 * TABLE_SIZE, 32'sh5555_5555);
        send_item(CMD_DELETE, 32'd0, 32'sd0);
        send_item(CMD_SEARCH, 32'd0, 32'sd0);                          // tombstone then empty
        send_item(CMD_SEARCH, TABLE_SIZE, 32'sd0);                     // walks past tombstone
        send_item(CMD_SEARCH, 2 * TABLE_SIZE, 32'sd0);
        send_item(CMD_DELETE, 32'd0, 32'sd0);                          // already gone
        send_item(CMD_INSERT, 32'd0, 32'shAAAA_AAAA);                  // tombstone not reused
        send_item(CMD_SEARCH, 32'd0, 32'sd0);
        // last slot, probe wraps around the table end
        send_item(CMD_INSERT, TABLE_SIZE - 1, 32'sd1);
        send_item(CMD_INSERT, 2 * TABLE_SIZE - 1, 32'sd2);
        send_item(CMD_DELETE, TABLE_SIZE, 32'sd0);
        send_item(CMD_SEARCH, 2 * TABLE_SIZE, 32'sd0);
        send_item(CMD_SEARCH, 2 * TABLE_SIZE - 1, 32'sd0);
        send_item(CMD_UNUSED, 32'd0, 32'sd0);
        drain_table();

        // fill: mostly new keys, with lookups, deletes and duplicates mixed in,
        // until no empty slot is left
        while (slots_taken < TABLE_SIZE)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
                send_item(CMD_INSERT, pick_key(0), $urandom);
            else if (pick < 86)
                send_item(CMD_INSERT, pick_key(100), $urandom);
            else if (pick < 93)
                send_item(CMD_SEARCH, pick_key(70), $urandom);
            else if (pick < 98)
                send_item(CMD_DELETE, pick_key(75), $urandom);
            else
                send_item(CMD_UNUSED, $urandom, $urandom);
            sent++;
            if (sent % DRAIN_EVERY == 0)
                drain_table();
        end

        // full table: misses walk every slot, new inserts report full,
        // deleted slots stay tombstones
        repeat (FULL_TABLE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_item(CMD_SEARCH, pick_key(100), $urandom);
            else if (pick < 50)
                send_item(CMD_SEARCH, pick_key(0), $urandom);
            else if (pick < 62)
                send_item(CMD_INSERT, pick_key(0), $urandom);
            else if (pick < 72)
                send_item(CMD_INSERT, pick_key(100), $urandom);
            else if (pick < 90)
                send_item(CMD_DELETE, pick_key(100), $urandom);
            else
                send_item(CMD_UNUSED, $urandom, $urandom);
        end

        drain_table();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin : watchdog
        #120_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> double_hash_key_value_table.f
rtl/dhkv_pkg.sv
rtl/dhkv_ram.sv
rtl/dhkv_seq.sv
rtl/dhkv_dp.sv
rtl/double_hash_key_value_table.sv
rtl/dhkv_checker.sv
tb/kv_table_checker.sv
tb/double_hash_key_value_table_tb.sv
